// File: src/kjp_pkg.sv
// ----------------------------------------------------------------------------
// kjp_pkg
// Shared types and constants for the keyboard and joystick port block.
// ----------------------------------------------------------------------------
package kjp_pkg;

  localparam int KEY_ROWS = 8;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  localparam logic [7:0] PORT_JOY_A    = 8'h1F;
  localparam logic [7:0] PORT_JOY_B    = 8'h7F;
  localparam logic [7:0] PORT_PRINTER  = 8'hFB;
  localparam logic [7:0] PORT_KEY_ROW  = 8'h7E;
  localparam logic [7:0] PORT_BORDER   = 8'hFE;
  localparam logic [7:0] PORT_NMI      = 8'hFF;

  localparam logic [7:0] RST_JOY_A   = 8'hFF;
  localparam logic [7:0] RST_JOY_B   = 8'h00;
  localparam logic [7:0] RST_PRINTER = 8'h40;
  localparam logic [7:0] RST_BORDER  = 8'hFF;
  localparam logic [7:0] RST_NMI     = 8'h00;
  localparam logic [7:0] RST_KEY_ROW = 8'hFF;
  localparam logic [7:0] IDLE_BYTE   = 8'hFF;

  typedef struct packed {
    logic       mode;
    logic [7:0] port;
    logic [7:0] row_select;
    logic [7:0] write_data;
  } kjp_access_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       port_matched;
    logic [7:0] nmi_value;
  } kjp_result_t;

endpackage

// File: src/kjp_port_file.sv
// ----------------------------------------------------------------------------
// kjp_port_file
// Port latches and keyboard row store, with the address decode for one
// transaction and the result it produces.
// ----------------------------------------------------------------------------
module kjp_port_file (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                commit,
  input  kjp_pkg::kjp_access_t acc,
  output kjp_pkg::kjp_result_t res
);

  logic [7:0] joy_a_r;
  logic [7:0] joy_b_r;
  logic [7:0] printer_r;
  logic [7:0] border_r;
  logic [7:0] nmi_r;
  logic [7:0] key_rows_r [kjp_pkg::KEY_ROWS];

  logic       wr_joy_a;
  logic       wr_joy_b;
  logic       wr_printer;
  logic       wr_border;
  logic       wr_nmi;
  logic       wr_key;
  logic       key_found;
  logic [2:0] key_row;
  logic [7:0] key_and;
  logic [7:0] rd_data;
  logic       hit;

  always_comb begin
    key_found = 1'b0;
    key_row   = '0;
    key_and   = kjp_pkg::IDLE_BYTE;
    for (int r = 0; r < kjp_pkg::KEY_ROWS; r++) begin
      if (!acc.row_select[kjp_pkg::KEY_ROWS-1-r]) begin
        key_and = key_and & key_rows_r[r];
        if (!key_found) begin
          key_found = 1'b1;
          key_row   = 3'(r);
        end
      end
    end
  end

  always_comb begin
    wr_joy_a   = 1'b0;
    wr_joy_b   = 1'b0;
    wr_printer = 1'b0;
    wr_border  = 1'b0;
    wr_nmi     = 1'b0;
    wr_key     = 1'b0;
    rd_data    = kjp_pkg::IDLE_BYTE;
    hit        = 1'b1;
    if (acc.mode == kjp_pkg::MODE_WRITE) begin
      case (acc.port)
        kjp_pkg::PORT_JOY_A:   wr_joy_a   = 1'b1;
        kjp_pkg::PORT_JOY_B:   wr_joy_b   = 1'b1;
        kjp_pkg::PORT_PRINTER: wr_printer = 1'b1;
        kjp_pkg::PORT_BORDER:  wr_border  = 1'b1;
        kjp_pkg::PORT_NMI:     wr_nmi     = 1'b1;
        kjp_pkg::PORT_KEY_ROW: wr_key     = key_found;
        default:               hit        = 1'b0;
      endcase
    end else begin
      case (acc.port)
        kjp_pkg::PORT_JOY_A:   rd_data = joy_a_r;
        kjp_pkg::PORT_JOY_B:   rd_data = joy_b_r;
        kjp_pkg::PORT_PRINTER: rd_data = printer_r;
        kjp_pkg::PORT_KEY_ROW: rd_data = border_r;
        kjp_pkg::PORT_BORDER:  rd_data = key_and;
        default:               hit     = 1'b0;
      endcase
    end
  end

  assign res.read_data    = rd_data;
  assign res.port_matched = hit;
  assign res.nmi_value    = wr_nmi ? acc.write_data : nmi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      joy_a_r   <= kjp_pkg::RST_JOY_A;
      joy_b_r   <= kjp_pkg::RST_JOY_B;
      printer_r <= kjp_pkg::RST_PRINTER;
      border_r  <= kjp_pkg::RST_BORDER;
      nmi_r     <= kjp_pkg::RST_NMI;
      for (int r = 0; r < kjp_pkg::KEY_ROWS; r++) begin
        key_rows_r[r] <= kjp_pkg::RST_KEY_ROW;
      end
    end else if (commit) begin
      if (wr_joy_a) begin
        joy_a_r <= acc.write_data;
      end
      if (wr_joy_b) begin
        joy_b_r <= acc.write_data;
      end
      if (wr_printer) begin
        printer_r <= acc.write_data;
      end
      if (wr_border) begin
        border_r <= acc.write_data;
      end
      if (wr_nmi) begin
        nmi_r <= acc.write_data;
      end
      if (wr_key) begin
        key_rows_r[key_row] <= acc.write_data;
      end
    end
  end

endmodule

// File: src/keyboard_joystick_port_block_top.sv
// ----------------------------------------------------------------------------
// keyboard_joystick_port_block_top
// Emulated I/O port block for a keyboard and joystick interface.
//
// Each input transaction is one bus access (mode, port, row_select,
// write_data); each produces exactly one output transaction carrying the read
// byte, a port-hit flag and the current NMI register.
// Both channels use valid and ready. An accepted access is held in an input
// register and decoded against the latches as it leaves that register; its
// result is loaded into the output register, and out_valid rises to present
// it to the receiver. Latches are updated as the access
// leaves the input register, so accesses take effect strictly in order.
// Throughput is one transaction per cycle while out_ready stays high. When the
// receiver stalls, the result is held in the output register and one further
// access may wait in the input register; in_ready then falls until the output
// register drains.
// Reset loads every latch and keyboard row with its default value and empties
// both registers; the block accepts an access in the first cycle after reset.
// ----------------------------------------------------------------------------
module keyboard_joystick_port_block_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_mode,
  input  logic [7:0] in_port,
  input  logic [7:0] in_row_select,
  input  logic [7:0] in_write_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_port_matched,
  output logic [7:0] out_nmi_value
);

  logic                 acc_valid_r;
  kjp_pkg::kjp_access_t acc_r;
  logic                 out_valid_r;
  kjp_pkg::kjp_result_t res_r;
  kjp_pkg::kjp_result_t res_nxt;
  logic                 advance;

  assign advance  = acc_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !acc_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_valid_r <= 1'b0;
    end else if (in_ready) begin
      acc_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      acc_r.mode       <= in_mode;
      acc_r.port       <= in_port;
      acc_r.row_select <= in_row_select;
      acc_r.write_data <= in_write_data;
    end
  end

  kjp_port_file u_port_file (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (advance),
    .acc    (acc_r),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= acc_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = res_r.read_data;
  assign out_port_matched = res_r.port_matched;
  assign out_nmi_value    = res_r.nmi_value;

endmodule

// File: src/kjp_checker.sv
// ----------------------------------------------------------------------------
// kjp_checker
// Port-level checks on the keyboard and joystick port block.
// ----------------------------------------------------------------------------
module kjp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_data,
  input logic       out_port_matched,
  input logic [7:0] out_nmi_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) &&
      $stable(out_port_matched) && $stable(out_nmi_value))
    else $error("Stalled output transaction changed or was dropped.");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("Output valid directly after reset.");

  a_miss_idle_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_port_matched |-> out_read_data == 8'hFF)
    else $error("Unmatched access returned data other than FF.");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("Input stalled while the output register is empty.");

endmodule

bind keyboard_joystick_port_block_top kjp_checker u_kjp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_read_data    (out_read_data),
  .out_port_matched (out_port_matched),
  .out_nmi_value    (out_nmi_value)
);

// File: tb/sv/keyboard_joystick_port_block_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_joystick_port_block_top_tb
// Drives bus accesses into the keyboard and joystick port block and checks
// every result transaction against a behavioural copy of the port latches and
// keyboard rows kept in the bench. Directed accesses cover the reset values,
// every port in both directions and the keyboard row cases; random traffic
// follows under varying idle rates, with one long receiver stall that fills
// the block and holds off its input.
// ----------------------------------------------------------------------------
module keyboard_joystick_port_block_top_tb;

  localparam int CYCLE_LIMIT = 200000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_mode;
  logic [7:0] in_port;
  logic [7:0] in_row_select;
  logic [7:0] in_write_data;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_read_data;
  logic       out_port_matched;
  logic [7:0] out_nmi_value;

  logic [7:0] joy_a_q;
  logic [7:0] joy_b_q;
  logic [7:0] printer_q;
  logic [7:0] border_q;
  logic [7:0] nmi_q;
  logic [7:0] key_rows_q [kjp_pkg::KEY_ROWS];

  kjp_pkg::kjp_result_t pending_results [$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  keyboard_joystick_port_block_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_port          (in_port),
    .in_row_select    (in_row_select),
    .in_write_data    (in_write_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_data    (out_read_data),
    .out_port_matched (out_port_matched),
    .out_nmi_value    (out_nmi_value)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void reset_port_state();
    joy_a_q   = kjp_pkg::RST_JOY_A;
    joy_b_q   = kjp_pkg::RST_JOY_B;
    printer_q = kjp_pkg::RST_PRINTER;
    border_q  = kjp_pkg::RST_BORDER;
    nmi_q     = kjp_pkg::RST_NMI;
    for (int r = 0; r < kjp_pkg::KEY_ROWS; r++) key_rows_q[r] = kjp_pkg::RST_KEY_ROW;
  endfunction

  function automatic kjp_pkg::kjp_result_t decode_access(kjp_pkg::kjp_access_t acc);
    kjp_pkg::kjp_result_t res;
    logic                 stored;
    res.read_data    = kjp_pkg::IDLE_BYTE;
    res.port_matched = 1'b1;
    stored           = 1'b0;
    if (acc.mode == kjp_pkg::MODE_WRITE) begin
      case (acc.port)
        kjp_pkg::PORT_JOY_A:   joy_a_q   = acc.write_data;
        kjp_pkg::PORT_JOY_B:   joy_b_q   = acc.write_data;
        kjp_pkg::PORT_PRINTER: printer_q = acc.write_data;
        kjp_pkg::PORT_BORDER:  border_q  = acc.write_data;
        kjp_pkg::PORT_NMI:     nmi_q     = acc.write_data;
        kjp_pkg::PORT_KEY_ROW: begin
          for (int r = 0; r < kjp_pkg::KEY_ROWS; r++) begin
            if (!stored && !acc.row_select[7 - r]) begin
              key_rows_q[r] = acc.write_data;
              stored = 1'b1;
            end
          end
        end
        default: res.port_matched = 1'b0;
      endcase
    end else begin
      case (acc.port)
        kjp_pkg::PORT_JOY_A:   res.read_data = joy_a_q;
        kjp_pkg::PORT_JOY_B:   res.read_data = joy_b_q;
        kjp_pkg::PORT_PRINTER: res.read_data = printer_q;
        kjp_pkg::PORT_KEY_ROW: res.read_data = border_q;
        kjp_pkg::PORT_BORDER: begin
          for (int r = 0; r < kjp_pkg::KEY_ROWS; r++)
            if (!acc.row_select[7 - r]) res.read_data &= key_rows_q[r];
        end
        default: res.port_matched = 1'b0;
      endcase
    end
    res.nmi_value = nmi_q;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatch_count++;
    $display("%0t: mismatch on %s: got %02h, expected %02h", $realtime, field, got, want);
  endtask

  task automatic send_access(input logic mode, input logic [7:0] port,
                             input logic [7:0] sel, input logic [7:0] data);
    kjp_pkg::kjp_access_t acc;
    acc.mode       = mode;
    acc.port       = port;
    acc.row_select = sel;
    acc.write_data = data;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_port       <= port;
    in_row_select <= sel;
    in_write_data <= data;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(decode_access(acc));
  endtask

  // The receiver owns its hold-off count; a test only posts a request.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    kjp_pkg::kjp_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction read_data", out_read_data,
                        kjp_pkg::IDLE_BYTE);
      end else begin
        want = pending_results.pop_front();
        if (out_read_data !== want.read_data)
          report_mismatch("read_data", out_read_data, want.read_data);
        if (out_port_matched !== want.port_matched)
          report_mismatch("port_matched", {7'd0, out_port_matched},
                          {7'd0, want.port_matched});
        if (out_nmi_value !== want.nmi_value)
          report_mismatch("nmi_value", out_nmi_value, want.nmi_value);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("keyboard_joystick_port_block_top_tb: errors");
      $finish;
    end
  end

  task automatic test_reset_reads();
    send_access(kjp_pkg::MODE_READ, kjp_pkg::PORT_JOY_A,   8'hFF, 8'h00);
    send_access(kjp_pkg::MODE_READ, kjp_pkg::PORT_JOY_B,   8'hFF, 8'h00);
    send_access(kjp_pkg::MODE_READ, kjp_pkg::PORT_PRINTER, 8'hFF, 8'h00);
    send_access(kjp_pkg::MODE_READ, kjp_pkg::PORT_KEY_ROW, 8'hFF, 8'h00);
    send_access(kjp_pkg::MODE_READ, kjp_pkg::PORT_BORDER,  8'h00, 8'h00);
    send_access(kjp_pkg::MODE_READ, kjp_pkg::PORT_NMI,     8'h00, 8'h00);
    send_access(kjp_pkg::MODE_READ, 8'h00,                 8'hFF, 8'hFF);
  endtask

  task automatic test_latch_writes();
    send_access(kjp_pkg::MODE_WRITE, kjp_pkg::PORT_JOY_A,   8'h00, 8'h00);
    send_access(kjp_pkg::MODE_WRITE, kjp_pkg::PORT_JOY_B,   8'hFF, 8'hFF);
    send_access(kjp_pkg::MODE_WRITE, kjp_pkg::PORT_PRINTER, 8'h55, 8'hA5);
    send_access(kjp_pkg::MODE_WRITE, kjp_pkg::PORT_BORDER,  8'hAA, 8'h5A);
    send_access(kjp_pkg::MODE_WRITE, kjp_pkg::PORT_NMI,     8'h00, 8'hFF);
    send_access(kjp_pkg::MODE_WRITE, 8'h00,                 8'h00, 8'h12);
    send_access(kjp_pkg::MODE_READ,  kjp_pkg::PORT_JOY_A,   8'h00, 8'h00);
    send_access(kjp_pkg::MODE_READ,  kjp_pkg::PORT_JOY_B,   8'h00, 8'h00);
    send_access(kjp_pkg::MODE_READ,  kjp_pkg::PORT_PRINTER, 8'h00, 8'h00);
    send_access(kjp_pkg::MODE_READ,  kjp_pkg::PORT_KEY_ROW, 8'h00, 8'h00);
  endtask

  task automatic test_keyboard_rows();
    send_access(kjp_pkg::MODE_WRITE, kjp_pkg::PORT_KEY_ROW, 8'h7F, 8'hFE);
    send_access(kjp_pkg::MODE_WRITE, kjp_pkg::PORT_KEY_ROW, 8'h00, 8'hBF);
    send_access(kjp_pkg::MODE_WRITE, kjp_pkg::PORT_KEY_ROW, 8'hFF, 8'h00);
    send_access(kjp_pkg::MODE_WRITE, kjp_pkg::PORT_KEY_ROW, 8'hFE, 8'h7F);
    send_access(kjp_pkg::MODE_READ,  kjp_pkg::PORT_BORDER,  8'h7E, 8'h00);
    send_access(kjp_pkg::MODE_READ,  kjp_pkg::PORT_BORDER,  8'hFF, 8'h00);
    send_access(kjp_pkg::MODE_READ,  kjp_pkg::PORT_BORDER,  8'h00, 8'h00);
  endtask

  function automatic logic [7:0] pick_port();
    case ($urandom_range(7))
      0:       return kjp_pkg::PORT_JOY_A;
      1:       return kjp_pkg::PORT_JOY_B;
      2:       return kjp_pkg::PORT_PRINTER;
      3:       return kjp_pkg::PORT_KEY_ROW;
      4:       return kjp_pkg::PORT_BORDER;
      5:       return kjp_pkg::PORT_NMI;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_row_select();
    case ($urandom_range(3))
      0:       return 8'hFF;
      1:       return ~(8'h01 << $urandom_range(7));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic test_random_traffic(input int count, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < count; i++)
      send_access(1'($urandom_range(1)), pick_port(), pick_row_select(), 8'($urandom));
  endtask

  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 40;
    for (int i = 0; i < 16; i++)
      send_access(1'($urandom_range(1)), pick_port(), pick_row_select(), 8'($urandom));
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_mode       = kjp_pkg::MODE_READ;
    in_port       = 8'h00;
    in_row_select = 8'hFF;
    in_write_data = 8'h00;
    out_ready     = 1'b0;
    reset_port_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 32;
    recv_idle_pct = 46;
    test_reset_reads();
    test_latch_writes();
    test_keyboard_rows();
    test_random_traffic(170, 32, 46);
    test_output_stall();
    test_random_traffic(170, 46, 32);
    test_random_traffic(170, 0, 0);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("keyboard_joystick_port_block_top_tb: clean");
    end else begin
      $display("keyboard_joystick_port_block_top_tb: errors");
    end
    $finish;
  end

endmodule
